[design/assert_macros.svh]
// Assertion macros shared by the rounding unit RTL.
// Needs clk and rst_n in the scope that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled in reset
`define LRH_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset
`define LRH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/lrh_pkg.sv]
// Package for the lattice rounding hint unit: widths, codes, reset values.
// No dependencies.
package lrh_pkg;

  localparam int LRH_DROP_BITS = 13;
  localparam int LRH_DATA_W    = 32;
  localparam int LRH_Q_W       = 31;
  localparam int LRH_G_W       = 30;
  localparam int LRH_M_W       = 10;
  localparam int LRH_CFG_IDX_W = 2;

  localparam logic [LRH_Q_W-1:0] LRH_Q_RST = 31'd8380417;
  localparam logic [LRH_G_W-1:0] LRH_G_RST = 30'd261888;
  localparam logic [LRH_M_W-1:0] LRH_M_RST = 10'd15;

  typedef enum logic [1:0] {
    CMD_SPLIT     = 2'd0,
    CMD_DECOMPOSE = 2'd1,
    CMD_MAKE_HINT = 2'd2,
    CMD_USE_HINT  = 2'd3
  } cmd_t;

  typedef enum logic [LRH_CFG_IDX_W-1:0] {
    CFG_MODULUS   = 2'd0,
    CFG_HALF_STEP = 2'd1,
    CFG_MAX_HIGH  = 2'd2
  } cfg_reg_t;

endpackage

[design/lrh_div.sv]
// Pipelined restoring divider, one quotient bit per stage, with a side tag.
// Standalone; divisor must be nonzero and stable while words are in flight.
module lrh_div #(
  parameter int NUM_W = 32,
  parameter int DEN_W = 31,
  parameter int TAG_W = 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [NUM_W-1:0] in_num,
  input  logic [DEN_W-1:0] den,
  input  logic [TAG_W-1:0] in_tag,
  output logic             out_valid,
  output logic [NUM_W-1:0] out_quot,
  output logic [DEN_W-1:0] out_rem,
  output logic [TAG_W-1:0] out_tag
);

  logic             v_r   [NUM_W];
  logic [DEN_W-1:0] rem_r [NUM_W];
  logic [NUM_W-1:0] nq_r  [NUM_W];
  logic [TAG_W-1:0] tag_r [NUM_W];

  for (genvar s = 0; s < NUM_W; s++) begin : g_stage
    logic             v_src;
    logic [DEN_W-1:0] rem_src;
    logic [NUM_W-1:0] nq_src;
    logic [TAG_W-1:0] tag_src;
    logic [DEN_W:0]   trial;
    logic             ge;
    logic [DEN_W-1:0] rem_nxt;
    logic [NUM_W-1:0] nq_nxt;

    if (s == 0) begin : g_first
      assign v_src   = in_valid;
      assign rem_src = '0;
      assign nq_src  = in_num;
      assign tag_src = in_tag;
    end else begin : g_rest
      assign v_src   = v_r[s-1];
      assign rem_src = rem_r[s-1];
      assign nq_src  = nq_r[s-1];
      assign tag_src = tag_r[s-1];
    end

    // shift in next numerator bit, subtract when it fits
    always_comb begin
      trial   = {rem_src, nq_src[NUM_W-1]};
      ge      = trial >= {1'b0, den};
      rem_nxt = ge ? DEN_W'(trial - {1'b0, den}) : trial[DEN_W-1:0];
      nq_nxt  = {nq_src[NUM_W-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s] <= 1'b0;
      end else begin
        v_r[s] <= v_src;
      end
    end

    always_ff @(posedge clk) begin
      rem_r[s] <= rem_nxt;
      nq_r[s]  <= nq_nxt;
      tag_r[s] <= tag_src;
    end
  end

  assign out_valid = v_r[NUM_W-1];
  assign out_quot  = nq_r[NUM_W-1];
  assign out_rem   = rem_r[NUM_W-1];
  assign out_tag   = tag_r[NUM_W-1];

endmodule

[design/lattice_rounding_hint_unit.sv]
// Top level of the lattice coefficient rounding unit (split, decompose, hints).
// Depends on lrh_pkg, lrh_div and assert_macros.svh.
//
// channel | ports                                   | handshake
// input   | in_command, in_value, in_second_operand | start & !busy
// result  | out_high_part, out_low_part, out_hint_bit | out_valid strobe
// config  | cfg_index, cfg_data                     | cfg_valid & cfg_ready
//
// One word accepted per cycle while busy is low. Each word passes in order
// through an input stage, two bit-serial divider pipelines (32 and 31 stages)
// with a remainder fixup stage between them, and three finishing stages.
// rst_n is synchronous; busy is high during reset and low afterwards.
// The result side has no back-pressure, so the pipeline never stalls.
`include "assert_macros.svh"

module lattice_rounding_hint_unit import lrh_pkg::*; #(
  parameter int DROP_BITS = LRH_DROP_BITS
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic [1:0]               in_command,
  input  logic signed [LRH_DATA_W-1:0] in_value,
  input  logic signed [LRH_DATA_W-1:0] in_second_operand,
  output logic                     out_valid,
  output logic signed [LRH_DATA_W-1:0] out_high_part,
  output logic signed [LRH_DATA_W-1:0] out_low_part,
  output logic                     out_hint_bit,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [LRH_CFG_IDX_W-1:0] cfg_index,
  input  logic [LRH_DATA_W-1:0]    cfg_data
);

  localparam int LAT = 68;
  localparam int T1_W = 2 + LRH_DATA_W + 1;
  localparam int T2_W = T1_W + LRH_Q_W;

  // configuration registers
  logic [LRH_Q_W-1:0] q_r;
  logic [LRH_G_W-1:0] g_r;
  logic [LRH_M_W-1:0] m_r;
  logic               busy_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r    <= LRH_Q_RST;
      g_r    <= LRH_G_RST;
      m_r    <= LRH_M_RST;
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          CFG_MODULUS:   q_r <= cfg_data[LRH_Q_W-1:0];
          CFG_HALF_STEP: g_r <= cfg_data[LRH_G_W-1:0];
          CFG_MAX_HIGH:  m_r <= cfg_data[LRH_M_W-1:0];
          default: ;
        endcase
      end
    end
  end

  assign busy = busy_r;

  // effective modulus and half step (zero reads as one)
  logic [LRH_Q_W-1:0] q_eff, d2;
  logic [LRH_G_W-1:0] g_eff;
  assign q_eff = (q_r == '0) ? LRH_Q_W'(1) : q_r;
  assign g_eff = (g_r == '0) ? LRH_G_W'(1) : g_r;
  assign d2    = {g_eff, 1'b0};

  // input stage
  logic                  s0_v_r;
  logic [1:0]            s0_cmd_r;
  logic [LRH_DATA_W-1:0] s0_a_r, s0_abs_r;
  logic                  s0_bnz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
    end else begin
      s0_v_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    s0_cmd_r <= in_command;
    s0_a_r   <= in_value;
    s0_abs_r <= in_value[LRH_DATA_W-1] ? LRH_DATA_W'(-in_value) : in_value;
    s0_bnz_r <= in_second_operand != '0;
  end

  // |a| mod q
  logic                  d1_v;
  logic [LRH_DATA_W-1:0] d1_quot;
  logic [LRH_Q_W-1:0]    d1_rem;
  logic [T1_W-1:0]       d1_tag;

  lrh_div #(.NUM_W(LRH_DATA_W), .DEN_W(LRH_Q_W), .TAG_W(T1_W)) u_div_mod (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s0_v_r),
    .in_num    (s0_abs_r),
    .den       (q_eff),
    .in_tag    ({s0_cmd_r, s0_a_r, s0_bnz_r}),
    .out_valid (d1_v),
    .out_quot  (d1_quot),
    .out_rem   (d1_rem),
    .out_tag   (d1_tag)
  );

  // fold negative values into [0,q)
  logic               r_v_r;
  logic [T1_W-1:0]    r_tag_r;
  logic [LRH_Q_W-1:0] r_r;
  logic               d1_neg;
  logic               d1_unused;

  assign d1_neg    = d1_tag[LRH_DATA_W];
  assign d1_unused = ^d1_quot;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r_v_r <= 1'b0;
    end else begin
      r_v_r <= d1_v;
    end
  end

  always_ff @(posedge clk) begin
    r_tag_r <= d1_tag;
    r_r     <= (d1_neg && d1_rem != '0) ? LRH_Q_W'(q_eff - d1_rem) : d1_rem;
  end

  // r / 2g
  logic               d2_v;
  logic [LRH_Q_W-1:0] d2_quot, d2_rem;
  logic [T2_W-1:0]    d2_tag;

  lrh_div #(.NUM_W(LRH_Q_W), .DEN_W(LRH_Q_W), .TAG_W(T2_W)) u_div_step (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (r_v_r),
    .in_num    (r_r),
    .den       (d2),
    .in_tag    ({r_tag_r, r_r}),
    .out_valid (d2_v),
    .out_quot  (d2_quot),
    .out_rem   (d2_rem),
    .out_tag   (d2_tag)
  );

  logic [1:0]                   t_cmd;
  logic signed [LRH_DATA_W-1:0] t_a;
  logic                         t_bnz;
  logic [LRH_Q_W-1:0]           t_r;
  assign {t_cmd, t_a, t_bnz, t_r} = d2_tag;

  // finish 1: center low part, split and make hint
  logic                         f1_v_r;
  logic [1:0]                   f1_cmd_r;
  logic                         f1_bnz_r, f1_hint_r;
  logic [LRH_Q_W-1:0]           f1_r_r;
  logic signed [LRH_DATA_W-1:0] f1_l_r, f1_hid_r, f1_shi_r, f1_slo_r;

  logic                         adj;
  logic signed [LRH_DATA_W:0]   xs, a33, g33, qmg;
  logic signed [LRH_DATA_W-1:0] shi;

  always_comb begin
    adj = d2_rem > LRH_Q_W'(g_eff);
    a33 = {t_a[LRH_DATA_W-1], t_a};
    xs  = a33 + ((LRH_DATA_W+1)'(1) <<< (DROP_BITS - 1)) - (LRH_DATA_W+1)'(1);
    shi = LRH_DATA_W'(xs >>> DROP_BITS);
    g33 = (LRH_DATA_W+1)'(g_eff);
    qmg = (LRH_DATA_W+1)'(q_eff) - g33;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_v_r <= 1'b0;
    end else begin
      f1_v_r <= d2_v;
    end
  end

  always_ff @(posedge clk) begin
    f1_cmd_r  <= t_cmd;
    f1_bnz_r  <= t_bnz;
    f1_r_r    <= t_r;
    f1_l_r    <= adj ? LRH_DATA_W'({1'b0, d2_rem} - {1'b0, d2})
                     : LRH_DATA_W'(d2_rem);
    f1_hid_r  <= LRH_DATA_W'(d2_quot) + LRH_DATA_W'(adj);
    f1_shi_r  <= shi;
    f1_slo_r  <= t_a - (shi <<< DROP_BITS);
    f1_hint_r <= !((a33 <= g33) || (a33 > qmg) || (a33 == qmg && !t_bnz));
  end

  // finish 2: wrap case q-1
  logic                         f2_v_r;
  logic [1:0]                   f2_cmd_r;
  logic                         f2_bnz_r, f2_hint_r, f2_wrap_r;
  logic signed [LRH_DATA_W-1:0] f2_lo_r, f2_hi_r, f2_shi_r, f2_slo_r;
  logic signed [LRH_DATA_W:0]   rl;
  logic                         wrap;

  always_comb begin
    rl   = (LRH_DATA_W+1)'(f1_r_r) - {f1_l_r[LRH_DATA_W-1], f1_l_r};
    wrap = rl == (LRH_DATA_W+1)'(q_eff - LRH_Q_W'(1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f2_v_r <= 1'b0;
    end else begin
      f2_v_r <= f1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    f2_cmd_r  <= f1_cmd_r;
    f2_bnz_r  <= f1_bnz_r;
    f2_hint_r <= f1_hint_r;
    f2_wrap_r <= wrap;
    f2_lo_r   <= wrap ? f1_l_r - LRH_DATA_W'(1) : f1_l_r;
    f2_hi_r   <= wrap ? '0 : f1_hid_r;
    f2_shi_r  <= f1_shi_r;
    f2_slo_r  <= f1_slo_r;
  end

  // finish 3: use hint and result select
  logic                         out_valid_r, out_hint_r;
  logic signed [LRH_DATA_W-1:0] out_hi_r, out_lo_r;
  logic signed [LRH_DATA_W-1:0] uh_hi, m32;
  logic signed [LRH_DATA_W-1:0] hi_nxt, lo_nxt;
  logic                         hint_nxt;

  always_comb begin
    m32 = LRH_DATA_W'(m_r);
    uh_hi = f2_hi_r;
    if (f2_bnz_r) begin
      if (f2_lo_r > 0) begin
        uh_hi = (f2_hi_r == m32) ? '0 : f2_hi_r + LRH_DATA_W'(1);
      end else begin
        uh_hi = (f2_hi_r == '0) ? m32 : f2_hi_r - LRH_DATA_W'(1);
      end
    end
    hi_nxt   = '0;
    lo_nxt   = '0;
    hint_nxt = 1'b0;
    case (cmd_t'(f2_cmd_r))
      CMD_SPLIT: begin
        hi_nxt = f2_shi_r;
        lo_nxt = f2_slo_r;
      end
      CMD_DECOMPOSE: begin
        hi_nxt = f2_hi_r;
        lo_nxt = f2_lo_r;
      end
      CMD_MAKE_HINT: hint_nxt = f2_hint_r;
      CMD_USE_HINT:  hi_nxt = uh_hi;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= f2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    out_hi_r   <= hi_nxt;
    out_lo_r   <= lo_nxt;
    out_hint_r <= hint_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_high_part = out_hi_r;
  assign out_low_part  = out_lo_r;
  assign out_hint_bit  = out_hint_r ^ (d1_unused & 1'b0);

  // checks
  `LRH_ASSERT(a_latency, start && !busy, ##LAT out_valid, "result missing after accept")
  `LRH_ASSERT(a_hint_alone, out_valid && out_hint_bit,
    out_high_part == 0 && out_low_part == 0, "hint with nonzero parts")
  `LRH_ASSERT(a_low_range, f2_v_r && f2_cmd_r == CMD_DECOMPOSE && !f2_wrap_r,
    $signed({f2_lo_r[LRH_DATA_W-1], f2_lo_r}) > -g33 &&
    $signed({f2_lo_r[LRH_DATA_W-1], f2_lo_r}) <= g33, "decompose low part out of range")
  `LRH_ASSERT_NEXT(a_no_spurious, !f2_v_r, !out_valid, "result without an item")

endmodule
